FILE: src/ccpc_pkg.sv
// Package of types and constants shared by the Collatz cycle pattern checker modules.
`default_nettype none

package ccpc_pkg;

	localparam int PATTERN_W = 40;
	localparam int NEXT_W    = 41;
	localparam int LEN_W     = 6;
	localparam int MAP_W     = 64;
	localparam int FIX_CNT_W = 7;

	localparam logic [FIX_CNT_W-1:0] FIX_LIMIT  = 7'd64;
	localparam logic [2:0]           TRIV_GROUP = 3'd4;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic fix_done;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: src/ccpc_datapath.sv
// Datapath: bit walk of the affine map, length and trivial checks, next-pattern fix-up loop.
`default_nettype none

module ccpc_datapath
	import ccpc_pkg::*;
#(
	parameter int PATTERN_BITS = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ctrl_cmd_t            cmd,
	output dp_sts_t                   sts,
	input  wire logic [PATTERN_W-1:0] pattern,
	output logic                      is_cycle,
	output logic                      is_trivial,
	output logic [LEN_W-1:0]          length,
	output logic [NEXT_W-1:0]         next_pattern,
	output logic                      search_done
);

	localparam int KW = $clog2(PATTERN_BITS);

	logic [PATTERN_BITS-1:0] p;
	logic                    rej;
	logic [PATTERN_BITS-1:0] sh_q;
	logic [PATTERN_BITS-1:0] t_q;
	logic [KW-1:0]           k_q;
	logic                    started_q;
	logic                    started_n;
	logic                    bit_cur;
	logic [MAP_W-1:0]        a_q;
	logic [MAP_W-1:0]        b_q;
	logic [MAP_W-1:0]        a3;
	logic [LEN_W-1:0]        len_q;
	logic                    triv_q;
	logic                    rej_q;
	logic [MAP_W-1:0]        v_q;
	logic [MAP_W-1:0]        u;
	logic [FIX_CNT_W-1:0]    it_q;
	logic                    walk_done_q;
	logic                    fix_done_q;

	always_comb begin
		p         = pattern[PATTERN_BITS-1:0];
		rej       = p[0] | (|(p & {p[PATTERN_BITS-2:0], 1'b0}));
		bit_cur   = sh_q[PATTERN_BITS-1];
		started_n = started_q | bit_cur;
		a3        = (a_q << 1) + a_q + b_q;
		u         = v_q & (v_q >> 1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q      <= p;
			t_q       <= p;
			k_q       <= KW'(PATTERN_BITS - 1);
			started_q <= 1'b0;
			a_q       <= MAP_W'(1);
			b_q       <= MAP_W'(1);
			len_q     <= '0;
			triv_q    <= 1'b1;
			rej_q     <= rej;
			v_q       <= MAP_W'(p) + MAP_W'(2);
			it_q      <= '0;
		end else if (cmd.step) begin
			if (!walk_done_q) begin
				started_q <= started_n;
				if (started_n || (k_q == '0)) begin
					if (bit_cur) begin
						a_q <= a3;
					end else begin
						b_q <= b_q << 1;
					end
				end
				if (bit_cur && !started_q) begin
					len_q <= LEN_W'(k_q) + LEN_W'(1);
				end
				if ((t_q != '0) && (t_q[2:0] != TRIV_GROUP)) begin
					triv_q <= 1'b0;
				end
				t_q  <= t_q >> 3;
				sh_q <= sh_q << 1;
				if (k_q != '0) begin
					k_q <= k_q - KW'(1);
				end
			end
			if (!fix_done_q && (u != '0) && (it_q != FIX_LIMIT)) begin
				v_q  <= v_q + u;
				it_q <= it_q + FIX_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_done_q <= 1'b0;
			fix_done_q  <= 1'b0;
		end else if (cmd.load) begin
			walk_done_q <= 1'b0;
			fix_done_q  <= 1'b0;
		end else if (cmd.step) begin
			if (!walk_done_q && (k_q == '0)) begin
				walk_done_q <= 1'b1;
			end
			if ((u == '0) || (it_q == FIX_LIMIT)) begin
				fix_done_q <= 1'b1;
			end
		end
	end

	always_comb begin
		sts.walk_done = walk_done_q;
		sts.fix_done  = fix_done_q;
		is_cycle      = !rej_q && (a_q == b_q);
		is_trivial    = triv_q;
		length        = len_q;
		next_pattern  = v_q[NEXT_W-1:0];
		search_done   = ((v_q[NEXT_W-1:0] >> PATTERN_BITS) != '0);
	end

endmodule

`default_nettype wire

FILE: src/ccpc_ctrl.sv
// Controller state machine: accepts a beat, runs the datapath and strobes the result.
`default_nettype none

module ccpc_ctrl
	import ccpc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	output logic         done,
	output ctrl_cmd_t    cmd,
	input  wire dp_sts_t sts
);

	ctrl_state_t state_q;
	ctrl_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		busy     = 1'b0;
		done     = 1'b0;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_n  = ST_RUN;
				end
			end
			ST_RUN: begin
				busy     = 1'b1;
				cmd.step = 1'b1;
				if (sts.walk_done && sts.fix_done) begin
					done    = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/collatz_cycle_pattern_checker_top.sv
// Top level of the Collatz cycle pattern checker: controller, datapath and assertions.
`default_nettype none

// One pattern is checked at a time. A beat is taken when start is high and busy is low; the
// result appears on the result ports with done high for exactly one cycle, and must be taken
// then, since the block holds it only until the next beat is taken. The next-pattern search
// makes at most 64 carry-fix additions; start is taken again in the cycle after done. The run
// time is set by the map walk, which handles one pattern bit per cycle from the top bit down,
// and by the fix-up adder, one addition a cycle.

module collatz_cycle_pattern_checker_top
	import ccpc_pkg::*;
#(
	parameter int PATTERN_BITS = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [PATTERN_W-1:0] pattern,
	output logic                      done,
	output logic                      is_cycle,
	output logic                      is_trivial,
	output logic [LEN_W-1:0]          length,
	output logic [NEXT_W-1:0]         next_pattern,
	output logic                      search_done
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	ccpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	ccpc_datapath #(
		.PATTERN_BITS (PATTERN_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.pattern      (pattern),
		.is_cycle     (is_cycle),
		.is_trivial   (is_trivial),
		.length       (length),
		.next_pattern (next_pattern),
		.search_done  (search_done)
	);

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not make the block busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block stayed busy after delivering a result");

	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (length <= LEN_W'(PATTERN_BITS)))
		else $error("result length exceeds the pattern width");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobed while idle");
`endif

endmodule

`default_nettype wire

FILE: tb/ccpc_result_checker.sv
// Checker that predicts and compares every result beat of the Collatz cycle pattern checker.
`timescale 1ns / 1ps

module ccpc_result_checker
	import ccpc_pkg::*;
#(
	parameter int PATTERN_BITS = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire logic [PATTERN_W-1:0] pattern,
	input  wire logic                 done,
	input  wire logic                 is_cycle,
	input  wire logic                 is_trivial,
	input  wire logic [LEN_W-1:0]     length,
	input  wire logic [NEXT_W-1:0]    next_pattern,
	input  wire logic                 search_done,
	output int                        mismatches,
	output int                        pending,
	output int                        results_seen,
	output int                        cycles_seen,
	output int                        trivial_seen,
	output int                        search_end_seen
);

	typedef struct packed {
		logic [PATTERN_W-1:0] pattern;
		logic                 is_cycle;
		logic                 is_trivial;
		logic [LEN_W-1:0]     length;
		logic [NEXT_W-1:0]    next_pattern;
		logic                 search_done;
	} pattern_verdict_t;

	pattern_verdict_t verdict_q[$];
	pattern_verdict_t want;

	initial begin
		mismatches      = 0;
		pending         = 0;
		results_seen    = 0;
		cycles_seen     = 0;
		trivial_seen    = 0;
		search_end_seen = 0;
	end

	function automatic pattern_verdict_t predict_verdict(input logic [PATTERN_W-1:0] raw);
		logic [63:0] lim, p, a, b, t, v;
		int          len, k, it;
		pattern_verdict_t r;
		lim = 64'd1 << PATTERN_BITS;
		p = {{(64-PATTERN_W){1'b0}}, raw} & (lim - 64'd1);
		r.pattern = raw;
		len = 0;
		for (k = 0; k < 64; k++) begin
			if (p[k])
				len = k + 1;
		end
		r.length = len[LEN_W-1:0];
		// The walk composes the affine map from the top bit down, starting at a = b = 1.
		r.is_cycle = 1'b0;
		if (!p[0] && (p & (p << 1)) == 64'd0) begin
			a = 64'd1;
			b = 64'd1;
			for (k = (len == 0) ? 0 : len - 1; k >= 0; k--) begin
				if (p[k])
					a = 64'd3 * a + b;
				else
					b = 64'd2 * b;
			end
			r.is_cycle = (a == b);
		end
		r.is_trivial = 1'b1;
		for (t = p; t != 64'd0; t = t >> 3) begin
			if (t[2:0] != TRIV_GROUP)
				r.is_trivial = 1'b0;
		end
		v = p + 64'd2;
		for (it = 0; it < int'(FIX_LIMIT) && (v & (v >> 1)) != 64'd0; it++)
			v = v + (v & (v >> 1));
		r.next_pattern = v[NEXT_W-1:0];
		r.search_done = ({{(64-NEXT_W){1'b0}}, v[NEXT_W-1:0]} >= lim);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [PATTERN_W-1:0] pat,
			input logic [63:0] exp_val, input logic [63:0] got_val);
		if (exp_val !== got_val) begin
			mismatches++;
			$display("%0t ns: pattern %h, %s expected %h, actual %h",
				$time, pat, name, exp_val, got_val);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (verdict_q.size() == 0) begin
					mismatches++;
					$display("%0t ns: result beat with none expected, next_pattern %h",
						$time, next_pattern);
				end else begin
					want = verdict_q.pop_front();
					check_field("is_cycle", want.pattern, 64'(want.is_cycle),
						64'(is_cycle));
					check_field("is_trivial", want.pattern, 64'(want.is_trivial),
						64'(is_trivial));
					check_field("length", want.pattern, 64'(want.length), 64'(length));
					check_field("next_pattern", want.pattern, 64'(want.next_pattern),
						64'(next_pattern));
					check_field("search_done", want.pattern, 64'(want.search_done),
						64'(search_done));
				end
			end
			if (start && !busy) begin
				want = predict_verdict(pattern);
				cycles_seen += int'(want.is_cycle);
				trivial_seen += int'(want.is_trivial);
				search_end_seen += int'(want.search_done);
				verdict_q.push_back(want);
			end
			pending <= verdict_q.size();
		end
	end

endmodule

FILE: tb/tb_collatz_cycle_pattern_checker_top.sv
// Testbench top for the Collatz cycle pattern checker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_collatz_cycle_pattern_checker_top;
	import ccpc_pkg::*;

	localparam int PATTERN_BITS = 40;
	localparam int N_RANDOM     = 1030;
	localparam int IDLE_LIMIT   = 1000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [PATTERN_W-1:0] pattern = '0;
	logic                 busy;
	logic                 done;
	logic                 is_cycle;
	logic                 is_trivial;
	logic [LEN_W-1:0]     length;
	logic [NEXT_W-1:0]    next_pattern;
	logic                 search_done;

	int mismatches, pending, results_seen, cycles_seen, trivial_seen, search_end_seen;
	int idle_cycles = 0;
	int items_sent = 0;
	int shaped_sent = 0;
	bit gaps_on = 1'b1;

	logic [PATTERN_W-1:0] directed [18] = '{
		40'h0, 40'h1, 40'h2, 40'h3, 40'h4, 40'h6, 40'h10, 40'h24, 40'h28, 40'h924,
		40'hAA_AAAA_AAAA, 40'h55_5555_5554, 40'hAA_AAAA_AAA8, 40'h80_0000_0000,
		40'h7F_FFFF_FFFE, 40'hFF_FFFF_FFFE, 40'hFF_FFFF_FFFF, 40'h92_4924_9249
	};

	collatz_cycle_pattern_checker_top #(
		.PATTERN_BITS(PATTERN_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pattern(pattern),
		.done(done),
		.is_cycle(is_cycle),
		.is_trivial(is_trivial),
		.length(length),
		.next_pattern(next_pattern),
		.search_done(search_done)
	);

	ccpc_result_checker #(
		.PATTERN_BITS(PATTERN_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pattern(pattern),
		.done(done),
		.is_cycle(is_cycle),
		.is_trivial(is_trivial),
		.length(length),
		.next_pattern(next_pattern),
		.search_done(search_done),
		.mismatches(mismatches),
		.pending(pending),
		.results_seen(results_seen),
		.cycles_seen(cycles_seen),
		.trivial_seen(trivial_seen),
		.search_end_seen(search_end_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout after %0d cycles without a beat", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_pattern(input logic [PATTERN_W-1:0] p);
		if (gaps_on) begin
			while ($urandom_range(99) < 17) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		pattern <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [63:0]          r;
		logic [63:0]          keep;
		logic [PATTERN_W-1:0] p;
		int                   i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_pattern(directed[i]);
		p = '0;
		repeat (13)
			p = {p[PATTERN_W-4:0], TRIV_GROUP};
		send_pattern(p);
		drain_results();

		for (i = 0; i < N_RANDOM; i++) begin
			gaps_on = !(i >= 400 && i < 600);
			if (i == 700)
				drain_results();
			r = {$urandom, $urandom};
			keep = (64'd1 << $urandom_range(PATTERN_BITS)) - 64'd1;
			case ($urandom_range(99)) inside
				[0:54]: begin
					// No two adjacent ones and an even low bit, as the search produces.
					r = r & keep;
					r = r & ~(r << 1) & ~64'd1;
					shaped_sent++;
				end
				[55:64]: begin
					r = '0;
					repeat ($urandom_range(1, 13))
						r = {r[60:0], TRIV_GROUP};
					if ($urandom_range(3) == 0)
						r[$urandom_range(PATTERN_BITS - 1)] ^= 1'b1;
					shaped_sent++;
				end
				[65:82]: r = r & keep;
				default: ;
			endcase
			send_pattern(r[PATTERN_W-1:0]);
		end

		drain_results();
		repeat (80) @(posedge clk);
		$display("Sent %0d patterns, %0d of them shaped as search candidates; %0d results checked.",
			items_sent, shaped_sent, results_seen);
		$display("Predicted %0d cycles, %0d trivial patterns and %0d search ends.",
			cycles_seen, trivial_seen, search_end_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
